// ===== hdl/vwbp_pkg.sv =====
// Shared types, codes and constants for the variable-width bit packer.
`default_nettype none
package vwbp_pkg;

	localparam int MAX_BUFFER_BYTES_DEF = 4096;
	localparam int WORD_BITS = 32;
	localparam int BYTE_BITS = 8;
	localparam int BUF_BYTES_W = 13;

	typedef enum logic [1:0] {
		OP_FIELD = 2'd0,
		OP_ALIGN = 2'd1,
		OP_FLUSH = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_OVERRUN  = 2'd1,
		ERR_PADDING  = 2'd2,
		ERR_TOO_WIDE = 2'd3
	} err_t;

	localparam logic CFG_STREAM_MODE  = 1'b0;
	localparam logic CFG_BUFFER_BYTES = 1'b1;

	localparam logic MODE_WRITER = 1'b0;
	localparam logic MODE_READER = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  bit_count;
		logic [31:0] field_value;
		logic [31:0] next_word;
	} item_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [31:0] out_word;
		logic        out_word_valid;
		logic        word_consumed;
		logic [12:0] bytes_done;
		err_t        error_code;
	} result_t;

	typedef struct packed {
		logic [63:0] scratch;
		logic [6:0]  count;
		logic [15:0] bit_total;
		logic [9:0]  word_pos;
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/vwbp_in_reg.sv =====
// Input register stage: captures one beat and holds it until the step stage advances.
`default_nettype none
module vwbp_in_reg
	import vwbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        advance,
	output logic             valid_s1,
	output item_t            item_s1
);

	always_comb begin
		s_tready = !valid_s1 || advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation   <= s_tuser;
			item_s1.bit_count   <= s_tdata[5:0];
			item_s1.field_value <= s_tdata[37:6];
			item_s1.next_word   <= s_tdata[69:38];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/vwbp_step.sv =====
// Step logic: packs or unpacks one field, pads, or flushes, from the held stream state.
`default_nettype none
module vwbp_step
	import vwbp_pkg::*;
#(
	parameter int MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF
) (
	input  wire logic                   mode,
	input  wire logic [BUF_BYTES_W-1:0] buffer_bytes,
	input  wire item_t                  item,
	input  wire state_t                 st,
	output state_t                      st_next,
	output result_t                     res
);

	localparam int MAX_W = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int CAP_W = (MAX_W > BUF_BYTES_W) ? MAX_W : BUF_BYTES_W;
	localparam int CW = (CAP_W + 3 > 17) ? CAP_W + 3 : 17;
	localparam logic [CAP_W-1:0] CAP = CAP_W'(MAX_BUFFER_BYTES);

	logic [CAP_W-1:0] bb_ext;
	logic [CAP_W-1:0] bb_eff;
	logic [CW-1:0]    buf_bits;

	always_comb begin
		bb_ext   = CAP_W'(buffer_bytes);
		bb_eff   = (bb_ext > CAP) ? CAP : bb_ext;
		buf_bits = CW'({bb_eff, 3'b000});
	end

	logic [5:0]  bits_sat;
	logic [2:0]  rem;
	logic [5:0]  pbits;
	logic        do_proc;
	logic        do_flush;
	logic        overrun;
	logic [63:0] mask64;
	logic        load;
	logic [63:0] sc_l;
	logic [6:0]  cnt_l;
	logic [31:0] rd;
	logic [31:0] wv;
	logic        too_wide;
	logic [63:0] sc_a;
	logic [6:0]  cnt_a;
	logic        emit;
	logic [63:0] sc_e;
	logic [6:0]  cnt_e;
	logic        emit_ok;
	logic [10:0] wp_inc;

	always_comb begin
		bits_sat = (item.bit_count > 6'(WORD_BITS)) ? 6'(WORD_BITS) : item.bit_count;
		rem      = st.bit_total[2:0];
		do_proc  = 1'b0;
		do_flush = 1'b0;
		pbits    = 6'd0;
		unique case (op_t'(item.operation))
			OP_FIELD: begin
				pbits   = bits_sat;
				do_proc = (bits_sat != 6'd0);
			end
			OP_ALIGN: begin
				pbits   = 6'(BYTE_BITS) - {3'b000, rem};
				do_proc = (rem != 3'd0);
			end
			OP_FLUSH: begin
				do_flush = (mode == MODE_WRITER) && (st.count != 7'd0);
			end
			default: begin
				pbits = 6'd0;
			end
		endcase

		overrun = (CW'(st.bit_total) + CW'(pbits)) > buf_bits;
		mask64  = (64'd1 << pbits) - 64'd1;

		load  = ({1'b0, pbits} > st.count);
		sc_l  = load ? (st.scratch | ({32'd0, item.next_word} << st.count[5:0])) : st.scratch;
		cnt_l = load ? (st.count + 7'(WORD_BITS)) : st.count;
		rd    = sc_l[31:0] & mask64[31:0];

		wv       = (op_t'(item.operation) == OP_FIELD) ? item.field_value : 32'd0;
		too_wide = |(wv & ~mask64[31:0]);
		sc_a     = st.scratch | ({32'd0, wv & mask64[31:0]} << st.count[5:0]);
		cnt_a    = st.count + {1'b0, pbits};

		emit  = 1'b0;
		sc_e  = st.scratch;
		cnt_e = st.count;
		if (do_proc && !overrun && mode == MODE_WRITER && cnt_a > 7'(WORD_BITS)) begin
			emit  = 1'b1;
			sc_e  = sc_a;
			cnt_e = cnt_a;
		end else if (do_flush) begin
			emit = 1'b1;
		end
		wp_inc  = {1'b0, st.word_pos} + 11'd1;
		emit_ok = CW'({wp_inc, 5'b00000}) <= buf_bits;

		st_next = st;
		res     = '0;

		if (do_proc) begin
			if (overrun) begin
				res.error_code = ERR_OVERRUN;
			end else begin
				st_next.bit_total = st.bit_total + 16'(pbits);
				if (mode == MODE_READER) begin
					st_next.scratch   = sc_l >> pbits;
					st_next.count     = cnt_l - {1'b0, pbits};
					res.read_value    = rd;
					res.word_consumed = load;
					if (load) begin
						st_next.word_pos = wp_inc[9:0];
					end
					if (op_t'(item.operation) == OP_ALIGN && rd != 32'd0) begin
						res.error_code = ERR_PADDING;
					end
				end else begin
					st_next.scratch = sc_a;
					st_next.count   = cnt_a;
					if (too_wide) begin
						res.error_code = ERR_TOO_WIDE;
					end
				end
			end
		end

		if (emit) begin
			st_next.scratch = sc_e >> WORD_BITS;
			st_next.count   = (cnt_e < 7'(WORD_BITS)) ? 7'd0 : (cnt_e - 7'(WORD_BITS));
			if (emit_ok) begin
				res.out_word       = sc_e[31:0];
				res.out_word_valid = 1'b1;
				st_next.word_pos   = wp_inc[9:0];
			end else begin
				res.error_code = ERR_OVERRUN;
			end
		end

		res.bytes_done = 13'({1'b0, st_next.bit_total[15:3]} + 14'(|st_next.bit_total[2:0]));
	end

endmodule
`default_nettype wire

// ===== hdl/vwbp_out_reg.sv =====
// Result register stage: holds one result beat until the sink takes it.
`default_nettype none
module vwbp_out_reg
	import vwbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire result_t     res,
	output logic             space,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,
	output logic [1:0]       m_tuser
);

	result_t res_s2;

	always_comb begin
		space   = !m_tvalid || m_tready;
		m_tdata = {1'b0, res_s2.error_code, res_s2.bytes_done,
			res_s2.out_word, res_s2.read_value};
		m_tuser = {res_s2.word_consumed, res_s2.out_word_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (space) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/variable_width_bit_packer_core.sv =====
// Top level of the LSB-first variable-width bit packer and unpacker.
// An accepted beat is held in the input register, then its result in the result register.
// One beat per cycle unless results stall; the stream state updates in the single step stage.
// Backpressure on the result side stalls the input side once two beats are held.
// Reset clears scratch, counts and positions, selects writer mode and 4096 bytes.
`default_nettype none
module variable_width_bit_packer_core
	import vwbp_pkg::*;
#(
	parameter int MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [71:0]            s_tdata,  // bit_count, field_value, next_word, pad
	input  wire logic [1:0]             s_tuser,  // operation
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [79:0]                 m_tdata,  // read_value, out_word, bytes_done, error_code, pad
	output logic [1:0]                  m_tuser,  // out_word_valid, word_consumed
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_index,
	input  wire logic [BUF_BYTES_W-1:0] cfg_data
);

	logic                   mode_q;
	logic [BUF_BYTES_W-1:0] buffer_bytes_q;
	state_t                 state_q;
	state_t                 state_next;
	result_t                res;
	item_t                  item_s1;
	logic                   valid_s1;
	logic                   space;
	logic                   advance;

	always_comb begin
		advance = valid_s1 && space;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_WRITER;
			buffer_bytes_q <= BUF_BYTES_W'(4096);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STREAM_MODE:  mode_q         <= cfg_data[0];
				CFG_BUFFER_BYTES: buffer_bytes_q <= cfg_data;
				default:          mode_q         <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	vwbp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	vwbp_step #(
		.MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
	) u_step (
		.mode         (mode_q),
		.buffer_bytes (buffer_bytes_q),
		.item         (item_s1),
		.st           (state_q),
		.st_next      (state_next),
		.res          (res)
	);

	vwbp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ===== hdl/vwbp_checker.sv =====
// Port-level checker for the bit packer core and its bind statement.
`default_nettype none
module vwbp_checker
	import vwbp_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [79:0]            m_tdata,
	input wire logic [1:0]             m_tuser
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_emit_xor_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("word emitted and consumed in one beat");

	a_overrun_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[78:77] == ERR_OVERRUN |-> m_tuser == 2'b00 && m_tdata[63:0] == 64'd0)
		else $error("overrun beat carries data");

	a_writer_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0 && m_tdata[78:77] != ERR_PADDING)
		else $error("emitted word beat carries read data");

endmodule

bind variable_width_bit_packer_core vwbp_checker u_vwbp_checker (.*);
`default_nettype wire
